@@ hw/rtl/rgb_to_hsv_converter_macros.svh @@
// assertion macros for the rgb to hsv converter checker
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RGBHSV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define RGBHSV_ASSERT_LAT(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rgbhsv_pkg.sv @@
// shared constants and types of the rgb to hsv converter
`default_nettype none
package rgbhsv_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int QUOT_BITS        = 12;          // quotient bits per division cell row
  localparam int HUE_BITS         = 15;
  localparam int SAT_BITS         = 8;
  localparam int SEXTANT          = 3840;        // 60 degrees in 1/64 degree
  localparam int FULL_CIRCLE      = 23040;       // 360 degrees in 1/64 degree
  localparam int SAT_SCALE        = 255 * 16;    // 255 with four extra fraction bits
  localparam int PIPE_LATENCY     = QUOT_BITS + 2;

  typedef enum logic [1:0] {
    SEXT_RED   = 2'd0,
    SEXT_GREEN = 2'd1,
    SEXT_BLUE  = 2'd2
  } sextant_t;

  typedef struct packed {
    logic     grey;
    logic     neg;
    sextant_t sextant;
  } pix_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/rgbhsv_div_cell.sv @@
// one restoring division step for the hue and saturation quotients
`default_nettype none
module rgbhsv_div_cell #(
  parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF,
  parameter int SIDE_BITS    = 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               valid,
  input  wire logic [SIDE_BITS-1:0]               side,
  input  wire logic [CHANNEL_BITS-1:0]            hue_div,
  input  wire logic [CHANNEL_BITS-1:0]            hue_rem,
  input  wire logic [rgbhsv_pkg::QUOT_BITS-1:0]   hue_quo,
  input  wire logic [CHANNEL_BITS-1:0]            sat_div,
  input  wire logic [CHANNEL_BITS-1:0]            sat_rem,
  input  wire logic [rgbhsv_pkg::QUOT_BITS-1:0]   sat_quo,
  output logic                                    valid_q,
  output logic [SIDE_BITS-1:0]                    side_q,
  output logic [CHANNEL_BITS-1:0]                 hue_div_q,
  output logic [CHANNEL_BITS-1:0]                 hue_rem_q,
  output logic [rgbhsv_pkg::QUOT_BITS-1:0]        hue_quo_q,
  output logic [CHANNEL_BITS-1:0]                 sat_div_q,
  output logic [CHANNEL_BITS-1:0]                 sat_rem_q,
  output logic [rgbhsv_pkg::QUOT_BITS-1:0]        sat_quo_q
);

  localparam int QB = rgbhsv_pkg::QUOT_BITS;

  logic [CHANNEL_BITS:0]   hue_t;
  logic [CHANNEL_BITS:0]   sat_t;
  logic                    hue_ge;
  logic                    sat_ge;
  logic [CHANNEL_BITS-1:0] hue_rem_next;
  logic [CHANNEL_BITS-1:0] sat_rem_next;
  logic [QB-1:0]           hue_quo_next;
  logic [QB-1:0]           sat_quo_next;

  // bring down the next dividend bit, subtract when it fits, shift the
  // quotient bit in behind the remaining dividend bits
  always_comb begin
    hue_t  = {hue_rem, hue_quo[QB-1]};
    sat_t  = {sat_rem, sat_quo[QB-1]};
    hue_ge = hue_t >= {1'b0, hue_div};
    sat_ge = sat_t >= {1'b0, sat_div};
    hue_rem_next = hue_ge ? CHANNEL_BITS'(hue_t - {1'b0, hue_div}) : hue_t[CHANNEL_BITS-1:0];
    sat_rem_next = sat_ge ? CHANNEL_BITS'(sat_t - {1'b0, sat_div}) : sat_t[CHANNEL_BITS-1:0];
    hue_quo_next = {hue_quo[QB-2:0], hue_ge};
    sat_quo_next = {sat_quo[QB-2:0], sat_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid;
    end
  end

  always_ff @(posedge clk) begin
    side_q    <= side;
    hue_div_q <= hue_div;
    hue_rem_q <= hue_rem_next;
    hue_quo_q <= hue_quo_next;
    sat_div_q <= sat_div;
    sat_rem_q <= sat_rem_next;
    sat_quo_q <= sat_quo_next;
  end

endmodule
`default_nettype wire

@@ hw/rtl/rgbhsv_front.sv @@
// extremes, sextant pick and scaled dividends ahead of the division row
`default_nettype none
module rgbhsv_front #(
  parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             take,
  input  wire logic [CHANNEL_BITS-1:0]          red,
  input  wire logic [CHANNEL_BITS-1:0]          green,
  input  wire logic [CHANNEL_BITS-1:0]          blue,
  output logic                                  valid_q,
  output rgbhsv_pkg::pix_ctl_t                  ctl_q,
  output logic [CHANNEL_BITS-1:0]               bright_q,
  output logic [CHANNEL_BITS-1:0]               hue_div_q,
  output logic [CHANNEL_BITS-1:0]               hue_rem_q,
  output logic [rgbhsv_pkg::QUOT_BITS-1:0]      hue_quo_q,
  output logic [CHANNEL_BITS-1:0]               sat_div_q,
  output logic [CHANNEL_BITS-1:0]               sat_rem_q,
  output logic [rgbhsv_pkg::QUOT_BITS-1:0]      sat_quo_q
);

  localparam int QB = rgbhsv_pkg::QUOT_BITS;
  localparam int DW = CHANNEL_BITS + QB;

  logic [CHANNEL_BITS-1:0] mx;
  logic [CHANNEL_BITS-1:0] mn;
  logic [CHANNEL_BITS-1:0] rng;
  logic [CHANNEL_BITS:0]   sdiff;
  logic [CHANNEL_BITS-1:0] adiff;
  logic [DW-1:0]           hue_num;
  logic [DW-1:0]           sat_num;
  rgbhsv_pkg::pix_ctl_t    ctl;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    rng = mx - mn;

    // ties go red first, then green
    if (red == mx) begin
      ctl.sextant = rgbhsv_pkg::SEXT_RED;
      sdiff       = {1'b0, green} - {1'b0, blue};
    end else if (green == mx) begin
      ctl.sextant = rgbhsv_pkg::SEXT_GREEN;
      sdiff       = {1'b0, blue} - {1'b0, red};
    end else begin
      ctl.sextant = rgbhsv_pkg::SEXT_BLUE;
      sdiff       = {1'b0, red} - {1'b0, green};
    end
    ctl.neg  = sdiff[CHANNEL_BITS];
    ctl.grey = (mx == mn);
    adiff    = ctl.neg ? CHANNEL_BITS'(-sdiff) : sdiff[CHANNEL_BITS-1:0];

    // both quotients stay below 2**QB, so the upper part starts below the divisor
    hue_num = DW'(adiff) * DW'(rgbhsv_pkg::SEXTANT);
    sat_num = DW'(rng) * DW'(rgbhsv_pkg::SAT_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take;
    end
  end

  always_ff @(posedge clk) begin
    ctl_q     <= ctl;
    bright_q  <= mx;
    hue_div_q <= rng;
    hue_rem_q <= hue_num[DW-1:QB];
    hue_quo_q <= hue_num[QB-1:0];
    sat_div_q <= mx;
    sat_rem_q <= sat_num[DW-1:QB];
    sat_quo_q <= sat_num[QB-1:0];
  end

endmodule
`default_nettype wire

@@ hw/rtl/rgbhsv_back.sv @@
// sextant offset, wrap and grey override into the result register
`default_nettype none
module rgbhsv_back #(
  parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             valid,
  input  wire rgbhsv_pkg::pix_ctl_t             ctl,
  input  wire logic [CHANNEL_BITS-1:0]          bright,
  input  wire logic [rgbhsv_pkg::QUOT_BITS-1:0] hue_quo,
  input  wire logic [rgbhsv_pkg::QUOT_BITS-1:0] sat_quo,
  output logic                                  done,
  output logic [rgbhsv_pkg::HUE_BITS-1:0]       hue,
  output logic [rgbhsv_pkg::SAT_BITS-1:0]       saturation,
  output logic [CHANNEL_BITS-1:0]               brightness
);

  localparam int HW = rgbhsv_pkg::HUE_BITS + 1;

  logic signed [HW-1:0]               base;
  logic signed [HW-1:0]               delta;
  logic signed [HW-1:0]               sum;
  logic [rgbhsv_pkg::HUE_BITS-1:0]    hue_next;
  logic [rgbhsv_pkg::SAT_BITS-1:0]    sat_next;

  always_comb begin
    unique case (ctl.sextant)
      rgbhsv_pkg::SEXT_RED:   base = '0;
      rgbhsv_pkg::SEXT_GREEN: base = HW'(2 * rgbhsv_pkg::SEXTANT);
      rgbhsv_pkg::SEXT_BLUE:  base = HW'(4 * rgbhsv_pkg::SEXTANT);
      default:                base = '0;
    endcase
    delta = ctl.neg ? -$signed(HW'(hue_quo)) : $signed(HW'(hue_quo));
    sum   = base + delta;
    if (sum < 0) sum = sum + HW'(rgbhsv_pkg::FULL_CIRCLE);
    hue_next = ctl.grey ? '0 : sum[rgbhsv_pkg::HUE_BITS-1:0];
    // drop the four fraction bits of the saturation quotient
    sat_next = ctl.grey ? '0
             : sat_quo[rgbhsv_pkg::QUOT_BITS-1 -: rgbhsv_pkg::SAT_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  always_ff @(posedge clk) begin
    hue        <= hue_next;
    saturation <= sat_next;
    brightness <= bright;
  end

endmodule
`default_nettype wire

@@ hw/rtl/rgb_to_hsv_converter.sv @@
// top level of the pipelined rgb to hsv pixel converter
//
// usage:
// - input beat: drive red, green, blue and raise start; the beat is taken
//   at a rising edge where start is high and busy is low
// - busy is low in normal operation, so a new pixel can enter every cycle;
//   it is high only while rst is held
// - result beat: done is high for exactly one cycle with hue (1/64 degree),
//   saturation (255 = 1.0) and brightness (largest channel)
// - path: each input beat passes the front stage, twelve division cells and
//   the result register before its result shows
// - throughput: one pixel per clock outside reset, set by the row of division cells that
//   each resolve one quotient bit of both divisions per cycle
// - results leave in input order; the receiver cannot stall, none is needed
// - reset: synchronous rst clears every valid bit in the pipe, so pixels in
//   flight are dropped and done stays low until new pixels drain through
// - grey pixels (max equals min) give hue and saturation of zero
`default_nettype none
module rgb_to_hsv_converter #(
  parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [CHANNEL_BITS-1:0]      red,
  input  wire logic [CHANNEL_BITS-1:0]      green,
  input  wire logic [CHANNEL_BITS-1:0]      blue,
  output logic                              done,
  output logic [rgbhsv_pkg::HUE_BITS-1:0]   hue,
  output logic [rgbhsv_pkg::SAT_BITS-1:0]   saturation,
  output logic [CHANNEL_BITS-1:0]           brightness
);

  localparam int QB        = rgbhsv_pkg::QUOT_BITS;
  localparam int NCELL     = rgbhsv_pkg::QUOT_BITS;           // one cell per quotient bit
  localparam int CTL_BITS  = $bits(rgbhsv_pkg::pix_ctl_t);
  localparam int SIDE_BITS = CTL_BITS + CHANNEL_BITS;

  // pipe is always free to take a beat; it only refuses while in reset
  logic take;
  assign busy = rst;
  assign take = start & ~busy;

  // chain taps, index 0 is the front stage output, NCELL the last cell output
  logic                    valid_c   [0:NCELL];
  logic [SIDE_BITS-1:0]    side_c    [0:NCELL];
  logic [CHANNEL_BITS-1:0] hue_div_c [0:NCELL];
  logic [CHANNEL_BITS-1:0] hue_rem_c [0:NCELL];
  logic [QB-1:0]           hue_quo_c [0:NCELL];
  logic [CHANNEL_BITS-1:0] sat_div_c [0:NCELL];
  logic [CHANNEL_BITS-1:0] sat_rem_c [0:NCELL];
  logic [QB-1:0]           sat_quo_c [0:NCELL];

  rgbhsv_pkg::pix_ctl_t    front_ctl;
  logic [CHANNEL_BITS-1:0] front_bright;
  rgbhsv_pkg::pix_ctl_t    back_ctl;
  logic [CHANNEL_BITS-1:0] back_bright;

  // extremes, sextant and scaled dividends
  rgbhsv_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .valid_q   (valid_c[0]),
    .ctl_q     (front_ctl),
    .bright_q  (front_bright),
    .hue_div_q (hue_div_c[0]),
    .hue_rem_q (hue_rem_c[0]),
    .hue_quo_q (hue_quo_c[0]),
    .sat_div_q (sat_div_c[0]),
    .sat_rem_q (sat_rem_c[0]),
    .sat_quo_q (sat_quo_c[0])
  );

  // control bits and brightness ride along the division row
  assign side_c[0] = {front_ctl, front_bright};

  // row of division cells, each resolves one quotient bit per pixel
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rgbhsv_div_cell #(
      .CHANNEL_BITS(CHANNEL_BITS),
      .SIDE_BITS   (SIDE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid     (valid_c[i]),
      .side      (side_c[i]),
      .hue_div   (hue_div_c[i]),
      .hue_rem   (hue_rem_c[i]),
      .hue_quo   (hue_quo_c[i]),
      .sat_div   (sat_div_c[i]),
      .sat_rem   (sat_rem_c[i]),
      .sat_quo   (sat_quo_c[i]),
      .valid_q   (valid_c[i+1]),
      .side_q    (side_c[i+1]),
      .hue_div_q (hue_div_c[i+1]),
      .hue_rem_q (hue_rem_c[i+1]),
      .hue_quo_q (hue_quo_c[i+1]),
      .sat_div_q (sat_div_c[i+1]),
      .sat_rem_q (sat_rem_c[i+1]),
      .sat_quo_q (sat_quo_c[i+1])
    );
  end

  // remainders of the last cell are not needed, divisors neither
  assign back_ctl    = rgbhsv_pkg::pix_ctl_t'(side_c[NCELL][SIDE_BITS-1:CHANNEL_BITS]);
  assign back_bright = side_c[NCELL][CHANNEL_BITS-1:0];

  // offset, wrap and result register
  rgbhsv_back #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .valid      (valid_c[NCELL]),
    .ctl        (back_ctl),
    .bright     (back_bright),
    .hue_quo    (hue_quo_c[NCELL]),
    .sat_quo    (sat_quo_c[NCELL]),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

endmodule
`default_nettype wire

@@ hw/rtl/rgbhsv_checker.sv @@
// port level checks of the rgb to hsv converter and their binding
`default_nettype none
`include "rgb_to_hsv_converter_macros.svh"
module rgbhsv_checker #(
  parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            done,
  input wire logic [rgbhsv_pkg::HUE_BITS-1:0] hue,
  input wire logic [rgbhsv_pkg::SAT_BITS-1:0] saturation,
  input wire logic [CHANNEL_BITS-1:0]         brightness
);

  localparam int LAT = rgbhsv_pkg::PIPE_LATENCY;

  logic beat_in;
  assign beat_in = start & ~busy;

  // every input beat gives its result a fixed time later
  `RGBHSV_ASSERT_LAT(a_result_follows, beat_in, LAT, done, "input beat lost")
  // no result without an input beat at the matching time
  `RGBHSV_ASSERT_IMP(a_no_spurious, done, $past(beat_in, LAT), "result without input beat")
  // hue stays below a full circle
  `RGBHSV_ASSERT_IMP(a_hue_range, done, hue < rgbhsv_pkg::HUE_BITS'(rgbhsv_pkg::FULL_CIRCLE),
    "hue out of range")
  // a black pixel is grey
  `RGBHSV_ASSERT_IMP(a_black_grey, done && (brightness == '0),
    (hue == '0) && (saturation == '0), "black pixel not grey")

endmodule

bind rgb_to_hsv_converter rgbhsv_checker #(
  .CHANNEL_BITS(CHANNEL_BITS)
) u_rgbhsv_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .hue        (hue),
  .saturation (saturation),
  .brightness (brightness)
);
`default_nettype wire
